// File: hw/rtl/dtpt_pkg.sv
// ----------------------------------------------------------------------------
// dtpt_pkg
// Shared types and constants of the door-triggered pump timer: mode codes,
// configuration register indexes, reset values and the words passed between
// the submodules.
// ----------------------------------------------------------------------------
package dtpt_pkg;

  // Field widths fixed by the register map
  localparam int HOLD_W        = 16;
  localparam int CFG_RUN_W     = 24;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 24;
  localparam int MODE_W        = 2;
  localparam int DEF_RUN_WIDTH = 24;

  // Register reset values
  localparam logic [HOLD_W-1:0]    RST_SHORT_HOLD = 16'd100;
  localparam logic [HOLD_W-1:0]    RST_LONG_HOLD  = 16'd300;
  localparam logic [HOLD_W-1:0]    RST_SETTLE     = 16'd200;
  localparam logic [HOLD_W-1:0]    RST_CANCEL     = 16'd300;
  localparam logic [CFG_RUN_W-1:0] RST_SHORT_RUN  = 24'd30000;
  localparam logic [CFG_RUN_W-1:0] RST_LONG_RUN   = 24'd60000;

  // Operating mode, also the encoding of the mode output
  typedef enum logic [MODE_W-1:0] {
    MODE_IDLE     = 2'd0,
    MODE_RESERVED = 2'd1,
    MODE_RUNNING  = 2'd2
  } mode_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SHORT_HOLD = 3'd0,
    CFG_LONG_HOLD  = 3'd1,
    CFG_SETTLE     = 3'd2,
    CFG_CANCEL     = 3'd3,
    CFG_SHORT_RUN  = 3'd4,
    CFG_LONG_RUN   = 3'd5
  } cfg_idx_t;

  // Effective settings: zero values already forced up to one
  typedef struct packed {
    logic [HOLD_W-1:0]    short_th;
    logic [HOLD_W-1:0]    long_th;
    logic [HOLD_W-1:0]    settle_th;
    logic [HOLD_W-1:0]    cancel_th;
    logic [CFG_RUN_W-1:0] short_run;
    logic [CFG_RUN_W-1:0] long_run;
  } cfg_t;

  // One result word
  typedef struct packed {
    logic          drive_on;
    logic [MODE_W-1:0] mode;
  } result_t;

endpackage

// File: hw/rtl/door_triggered_pump_timer.sv
// ----------------------------------------------------------------------------
// door_triggered_pump_timer
// Door-triggered recirculation timer: one door sample in, one output word out.
// ----------------------------------------------------------------------------
// One door-switch sample is taken per word and one result word (drive_on,
// mode) comes back for each via the output register or skid. A new sample
// is accepted every cycle while the skid is empty: mode machine, hold counter
// and run countdown all update per sample, and the one-entry skid behind the
// output register keeps in_ready high while one finished word waits on
// out_ready. The user writes settings (cfg_we/cfg_index/cfg_data) only while
// idle; the block does not enforce this. Zero thresholds and durations act
// as one, and run durations saturate at 2^RUN_WIDTH-1.
module door_triggered_pump_timer #(
  parameter int RUN_WIDTH = dtpt_pkg::DEF_RUN_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            door_open,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            drive_on,
  output logic [dtpt_pkg::MODE_W-1:0]     mode,
  input  logic                            cfg_we,
  input  logic [dtpt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dtpt_pkg::CFG_DATA_W-1:0] cfg_data
);
  import dtpt_pkg::*;

  cfg_t    cfg;
  result_t step_result;
  result_t out_word;
  logic    in_fire;

  assign in_fire = in_valid && in_ready;

  // Settings
  dtpt_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Mode machine
  dtpt_ctrl #(
    .RUN_WIDTH (RUN_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .step      (in_fire),
    .door_open (door_open),
    .cfg       (cfg),
    .result    (step_result)
  );

  // Result register and skid
  dtpt_out_skid u_out_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (in_fire),
    .push_data (step_result),
    .can_push  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_word)
  );

  assign drive_on = out_word.drive_on;
  assign mode     = out_word.mode;

endmodule

// File: hw/rtl/dtpt_cfg_regs.sv
// ----------------------------------------------------------------------------
// dtpt_cfg_regs
// Configuration register file. Holds the six settings and presents them with
// zero thresholds and durations read as one.
// ----------------------------------------------------------------------------
module dtpt_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [dtpt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dtpt_pkg::CFG_DATA_W-1:0] cfg_data,
  output dtpt_pkg::cfg_t                 cfg
);
  import dtpt_pkg::*;

  logic [HOLD_W-1:0]    short_hold;
  logic [HOLD_W-1:0]    long_hold;
  logic [HOLD_W-1:0]    settle;
  logic [HOLD_W-1:0]    cancel;
  logic [CFG_RUN_W-1:0] short_run;
  logic [CFG_RUN_W-1:0] long_run;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      short_hold <= RST_SHORT_HOLD;
      long_hold  <= RST_LONG_HOLD;
      settle     <= RST_SETTLE;
      cancel     <= RST_CANCEL;
      short_run  <= RST_SHORT_RUN;
      long_run   <= RST_LONG_RUN;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SHORT_HOLD: short_hold <= cfg_data[HOLD_W-1:0];
        CFG_LONG_HOLD:  long_hold  <= cfg_data[HOLD_W-1:0];
        CFG_SETTLE:     settle     <= cfg_data[HOLD_W-1:0];
        CFG_CANCEL:     cancel     <= cfg_data[HOLD_W-1:0];
        CFG_SHORT_RUN:  short_run  <= cfg_data[CFG_RUN_W-1:0];
        CFG_LONG_RUN:   long_run   <= cfg_data[CFG_RUN_W-1:0];
        default: ;
      endcase
    end
  end

  // Zero means one
  always_comb begin
    cfg.short_th  = (short_hold == '0) ? HOLD_W'(1) : short_hold;
    cfg.long_th   = (long_hold == '0)  ? HOLD_W'(1) : long_hold;
    cfg.settle_th = (settle == '0)     ? HOLD_W'(1) : settle;
    cfg.cancel_th = (cancel == '0)     ? HOLD_W'(1) : cancel;
    cfg.short_run = (short_run == '0)  ? CFG_RUN_W'(1) : short_run;
    cfg.long_run  = (long_run == '0)   ? CFG_RUN_W'(1) : long_run;
  end

endmodule

// File: hw/rtl/dtpt_ctrl.sv
// ----------------------------------------------------------------------------
// dtpt_ctrl
// Mode state machine with the hold counter and the run countdown. Advances
// once per accepted door sample and produces that sample's result word.
// ----------------------------------------------------------------------------
module dtpt_ctrl #(
  parameter int RUN_WIDTH = dtpt_pkg::DEF_RUN_WIDTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic              door_open,
  input  dtpt_pkg::cfg_t    cfg,
  output dtpt_pkg::result_t result
);
  import dtpt_pkg::*;

  mode_t                mode_reg, mode_reg_next;
  logic [HOLD_W-1:0]    hold_count, hold_count_next;
  logic                 reserve_long, reserve_long_next;
  logic [RUN_WIDTH-1:0] run_remaining, run_remaining_next;

  logic [CFG_RUN_W-1:0] dur_sel;
  logic [RUN_WIDTH-1:0] run_len;
  logic [HOLD_W-1:0]    cnt_limit;
  logic [HOLD_W-1:0]    cnt_up;
  logic [RUN_WIDTH-1:0] run_dec;

  // Reserved duration, saturated to the countdown width
  assign dur_sel = reserve_long ? cfg.long_run : cfg.short_run;

  generate
    if (RUN_WIDTH >= CFG_RUN_W) begin : g_wide
      assign run_len = RUN_WIDTH'(dur_sel);
    end else begin : g_narrow
      assign run_len = (|(dur_sel >> RUN_WIDTH)) ? {RUN_WIDTH{1'b1}}
                                                 : RUN_WIDTH'(dur_sel);
    end
  endgenerate

  // Saturating hold counter against the threshold of the current mode
  always_comb begin
    unique case (mode_reg)
      MODE_IDLE:     cnt_limit = cfg.long_th;
      MODE_RESERVED: cnt_limit = cfg.settle_th;
      MODE_RUNNING:  cnt_limit = cfg.cancel_th;
      default:       cnt_limit = cfg.long_th;
    endcase
    cnt_up = (hold_count < cnt_limit) ? hold_count + HOLD_W'(1) : cnt_limit;
  end

  assign run_dec = (run_remaining != '0) ? run_remaining - RUN_WIDTH'(1) : '0;

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg      <= MODE_IDLE;
      hold_count    <= '0;
      reserve_long  <= 1'b0;
      run_remaining <= '0;
    end else if (step) begin
      mode_reg      <= mode_reg_next;
      hold_count    <= hold_count_next;
      reserve_long  <= reserve_long_next;
      run_remaining <= run_remaining_next;
    end
  end

  // Next state and result word
  always_comb begin
    mode_reg_next      = mode_reg;
    hold_count_next    = hold_count;
    reserve_long_next  = reserve_long;
    run_remaining_next = run_remaining;

    unique case (mode_reg)
      MODE_IDLE: begin
        if (door_open) begin
          // long hold reserves at once
          if (cnt_up >= cfg.long_th) begin
            reserve_long_next = 1'b1;
            mode_reg_next     = MODE_RESERVED;
            hold_count_next   = '0;
          end else begin
            hold_count_next = cnt_up;
          end
        end else begin
          // release after a short hold
          if (hold_count >= cfg.short_th) begin
            reserve_long_next = (hold_count >= cfg.long_th);
            mode_reg_next     = MODE_RESERVED;
          end
          hold_count_next = '0;
        end
      end
      MODE_RESERVED: begin
        if (door_open) begin
          hold_count_next = '0;
        end else if (cnt_up >= cfg.settle_th) begin
          run_remaining_next = run_len;
          reserve_long_next  = 1'b0;
          hold_count_next    = '0;
          mode_reg_next      = MODE_RUNNING;
        end else begin
          hold_count_next = cnt_up;
        end
      end
      MODE_RUNNING: begin
        if (door_open) begin
          // held open: cancel check, no countdown
          if (cnt_up >= cfg.cancel_th) begin
            run_remaining_next = '0;
            hold_count_next    = '0;
            mode_reg_next      = MODE_IDLE;
          end else begin
            hold_count_next = cnt_up;
          end
        end else begin
          hold_count_next    = '0;
          run_remaining_next = run_dec;
          if (run_dec == '0) begin
            mode_reg_next = MODE_IDLE;
          end
        end
      end
      default: begin
        mode_reg_next   = MODE_IDLE;
        hold_count_next = '0;
      end
    endcase

    result.drive_on = (mode_reg_next == MODE_RUNNING);
    result.mode     = mode_reg_next;
  end

endmodule

// File: hw/rtl/dtpt_out_skid.sv
// ----------------------------------------------------------------------------
// dtpt_out_skid
// Output register with one skid entry. Upstream ready comes from a register,
// so a stalled output never blocks the word already in flight.
// ----------------------------------------------------------------------------
module dtpt_out_skid (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  dtpt_pkg::result_t push_data,
  output logic              can_push,
  output logic              out_valid,
  input  logic              out_ready,
  output dtpt_pkg::result_t out_data
);
  import dtpt_pkg::*;

  logic    skid_valid;
  result_t skid_data;

  assign can_push = !skid_valid;

  // Output slot and skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      // output slot frees this cycle
      if (skid_valid) begin
        out_data   <= skid_data;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else if (push) begin
        out_data  <= push_data;
        out_valid <= 1'b1;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (push) begin
      // output stalled: park the new word
      skid_data  <= push_data;
      skid_valid <= 1'b1;
    end
  end

endmodule

// File: sim/door_timer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// door_timer_checker
// Watches the door-sample and result channels of the pump timer, keeps its
// own copy of the settings and the mode machine, predicts one result word per
// accepted door word and compares each result word as it is taken.
// ----------------------------------------------------------------------------
module door_timer_checker #(
  parameter int RUN_WIDTH = dtpt_pkg::DEF_RUN_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic                            door_open,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic                            drive_on,
  input  logic [dtpt_pkg::MODE_W-1:0]     mode,
  input  logic                            cfg_we,
  input  logic [dtpt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dtpt_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              mismatches,
  output int                              words_due
);
  import dtpt_pkg::*;

  // Settings as written
  logic [HOLD_W-1:0]    set_short_hold;
  logic [HOLD_W-1:0]    set_long_hold;
  logic [HOLD_W-1:0]    set_settle;
  logic [HOLD_W-1:0]    set_cancel;
  logic [CFG_RUN_W-1:0] set_short_run;
  logic [CFG_RUN_W-1:0] set_long_run;

  // Predicted timer state
  mode_t             pump_mode;
  logic [HOLD_W-1:0] hold_ticks;
  logic              long_booked;
  logic [63:0]       run_left;

  result_t pump_results_due[$];

  // Zero thresholds behave as one
  function automatic logic [HOLD_W-1:0] at_least_one(input logic [HOLD_W-1:0] v);
    return (v == '0) ? HOLD_W'(1) : v;
  endfunction

  // Hold counter steps up and saturates at its threshold
  function automatic logic [HOLD_W-1:0] hold_step(input logic [HOLD_W-1:0] cnt,
                                                  input logic [HOLD_W-1:0] lim);
    return (cnt < lim) ? cnt + HOLD_W'(1) : lim;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] door timer: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin : track
    logic [HOLD_W-1:0] short_th, long_th, settle_th, cancel_th;
    logic [63:0]       cap, dur;
    result_t           want;
    if (rst) begin
      set_short_hold = RST_SHORT_HOLD;
      set_long_hold  = RST_LONG_HOLD;
      set_settle     = RST_SETTLE;
      set_cancel     = RST_CANCEL;
      set_short_run  = RST_SHORT_RUN;
      set_long_run   = RST_LONG_RUN;
      pump_mode      = MODE_IDLE;
      hold_ticks     = '0;
      long_booked    = 1'b0;
      run_left       = '0;
      pump_results_due.delete();
      mismatches     = 0;
    end else begin
      // register writes; unknown indexes fall through
      if (cfg_we) begin
        case (cfg_index)
          CFG_SHORT_HOLD: set_short_hold = cfg_data[HOLD_W-1:0];
          CFG_LONG_HOLD:  set_long_hold  = cfg_data[HOLD_W-1:0];
          CFG_SETTLE:     set_settle     = cfg_data[HOLD_W-1:0];
          CFG_CANCEL:     set_cancel     = cfg_data[HOLD_W-1:0];
          CFG_SHORT_RUN:  set_short_run  = cfg_data[CFG_RUN_W-1:0];
          CFG_LONG_RUN:   set_long_run   = cfg_data[CFG_RUN_W-1:0];
          default: ;
        endcase
      end

      // result word taken: compare with the oldest prediction
      if (out_valid && out_ready) begin
        if (pump_results_due.size() == 0) begin
          report_mismatch($sformatf("result word with nothing pending (drive_on=%b mode=%0d)",
                                    drive_on, mode));
        end else begin
          want = pump_results_due.pop_front();
          if (drive_on !== want.drive_on)
            report_mismatch($sformatf("drive_on expected %b, got %b", want.drive_on, drive_on));
          if (mode !== want.mode)
            report_mismatch($sformatf("mode expected %0d, got %0d", want.mode, mode));
        end
      end

      // door word taken: advance the mode machine
      if (in_valid && in_ready) begin
        short_th  = at_least_one(set_short_hold);
        long_th   = at_least_one(set_long_hold);
        settle_th = at_least_one(set_settle);
        cancel_th = at_least_one(set_cancel);
        case (pump_mode)
          MODE_IDLE: begin
            if (door_open) begin
              hold_ticks = hold_step(hold_ticks, long_th);
              if (hold_ticks >= long_th) begin
                long_booked = 1'b1;
                pump_mode   = MODE_RESERVED;
                hold_ticks  = '0;
              end
            end else begin
              // release tick only books the run
              if (hold_ticks >= short_th) begin
                long_booked = (hold_ticks >= long_th);
                pump_mode   = MODE_RESERVED;
              end
              hold_ticks = '0;
            end
          end
          MODE_RESERVED: begin
            if (door_open) begin
              hold_ticks = '0;
            end else begin
              hold_ticks = hold_step(hold_ticks, settle_th);
              if (hold_ticks >= settle_th) begin
                cap = (64'd1 << RUN_WIDTH) - 64'd1;
                dur = 64'(long_booked ? set_long_run : set_short_run);
                if (dur == '0) dur = 64'd1;
                if (dur > cap) dur = cap;
                run_left    = dur;
                long_booked = 1'b0;
                hold_ticks  = '0;
                pump_mode   = MODE_RUNNING;
              end
            end
          end
          MODE_RUNNING: begin
            if (door_open) begin
              // open ticks do not count the run down
              hold_ticks = hold_step(hold_ticks, cancel_th);
              if (hold_ticks >= cancel_th) begin
                run_left   = '0;
                hold_ticks = '0;
                pump_mode  = MODE_IDLE;
              end
            end else begin
              hold_ticks = '0;
              if (run_left > 0) run_left--;
              if (run_left == 0) pump_mode = MODE_IDLE;
            end
          end
          default: begin
            pump_mode  = MODE_IDLE;
            hold_ticks = '0;
          end
        endcase
        want.drive_on = (pump_mode == MODE_RUNNING);
        want.mode     = pump_mode;
        pump_results_due.push_back(want);
      end
    end
    words_due = pump_results_due.size();
  end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the door-triggered pump timer: directed door sequences for the
// zero-threshold, release, reopen, cancel and extreme-setting cases, then
// phases of random hold/close bursts under varied settings, with random gaps
// on both channels and one long receiver stall. Checking is in the checker.
// ----------------------------------------------------------------------------
module tb_top;
  import dtpt_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int STALL_CYCLES   = 48;
  localparam int GAP_PERCENT    = 29;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  door_open = 1'b0;
  logic                  out_ready = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_SHORT_HOLD;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_ready;
  logic                  out_valid;
  logic                  drive_on;
  logic [MODE_W-1:0]     mode;
  int                    mismatches;
  int                    words_due;

  // pacing controls and burst spans for the current settings
  bit pace_gaps   = 1'b1;
  int stall_req   = 0;
  int span_open   = 4;
  int span_settle = 4;
  int span_run    = 8;

  always #5 clk = ~clk;

  door_triggered_pump_timer u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .door_open (door_open),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .drive_on  (drive_on),
    .mode      (mode),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  door_timer_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .door_open  (door_open),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .drive_on   (drive_on),
    .mode       (mode),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .words_due  (words_due)
  );

  // Result side: random back-pressure, plus a long hold-off on request
  int stall_seen = 0;
  int stall_left = 0;
  always @(negedge clk) begin
    if (stall_req != stall_seen) begin
      stall_seen = stall_req;
      stall_left = STALL_CYCLES;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !(pace_gaps && $urandom_range(0, 99) < GAP_PERCENT);
    end
  end

  // Watchdog: too long without any word moving
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // One door word; entered and left at a falling edge
  task automatic send_door(input logic level);
    while (pace_gaps && $urandom_range(0, 99) < GAP_PERCENT) begin
      in_valid  <= 1'b0;
      door_open <= 1'($urandom_range(0, 1));
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    door_open <= level;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_run(input logic level, input int count);
    repeat (count) send_door(level);
  endtask

  // Stop offering and let every pending result word come back
  task automatic quiesce();
    in_valid <= 1'b0;
    while (words_due != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_DATA_W-1:0];
    @(negedge clk);
  endtask

  // Full register load, a write to an unused index, and new burst spans
  task automatic program_regs(input int hs, input int hl, input int st,
                              input int ca, input int rs, input int rl);
    write_reg(CFG_SHORT_HOLD, hs);
    write_reg(CFG_LONG_HOLD, hl);
    write_reg(CFG_SETTLE, st);
    write_reg(CFG_CANCEL, ca);
    write_reg(CFG_SHORT_RUN, rs);
    write_reg(CFG_LONG_RUN, rl);
    write_reg(CFG_SPARE_IDX, $urandom);
    cfg_we <= 1'b0;
    span_open = (hs > hl) ? hs : hl;
    if (ca > span_open) span_open = ca;
    span_open = ((span_open < 1) ? 1 : span_open) + 2;
    if (span_open > 40) span_open = 40;
    span_settle = ((st < 1) ? 1 : st) + 2;
    if (span_settle > 40) span_settle = 40;
    span_run = ((rs > rl) ? rs : rl) + 4;
    if (span_run > 60) span_run = 60;
  endtask

  task automatic program_random();
    program_regs($urandom_range(0, 6), $urandom_range(0, 12), $urandom_range(0, 8),
                 $urandom_range(0, 8), $urandom_range(0, 30), $urandom_range(0, 50));
  endtask

  // Alternating open/closed bursts sized to the thresholds, with some noise
  task automatic run_phase(input int n, input int stall_at);
    int   sent;
    int   burst;
    logic level;
    sent  = 0;
    level = 1'($urandom_range(0, 1));
    while (sent < n) begin
      level = ~level;
      if ($urandom_range(0, 99) < 12)      burst = 1;
      else if (level)                      burst = $urandom_range(1, span_open);
      else if ($urandom_range(0, 99) < 35) burst = $urandom_range(1, span_run);
      else                                 burst = $urandom_range(1, span_settle);
      while (burst > 0 && sent < n) begin
        send_door(level);
        sent++;
        burst--;
        if (sent == stall_at) stall_req <= stall_req + 1;
      end
    end
    quiesce();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: a short hold does nothing
    send_run(1'b1, 2);
    send_run(1'b0, 1);
    quiesce();

    // zero thresholds and durations: release, reopen, one-tick run, cancel, long run
    program_regs(0, 2, 0, 1, 0, 3);
    send_run(1'b0, 1);
    send_run(1'b1, 1);
    send_run(1'b0, 1);
    send_run(1'b1, 1);
    send_run(1'b0, 2);
    send_run(1'b1, 2);
    send_run(1'b0, 1);
    send_run(1'b1, 3);
    send_run(1'b0, 4);
    quiesce();

    // short above long, full-scale durations, cancel mid-run
    program_regs(65535, 1, 1, 2, 16777215, 16777215);
    send_run(1'b1, 1);
    send_run(1'b0, 2);
    send_run(1'b1, 2);
    quiesce();

    // random phases; the first one carries the long receiver stall
    program_random();
    run_phase(80, 30);
    pace_gaps <= 1'b0;
    program_random();
    run_phase(70, 0);
    pace_gaps <= 1'b1;
    program_regs(2, 65535, 0, 65535, 5, 16777215);
    run_phase(40, 0);
    program_regs(65535, 0, 65535, 0, 0, 0);
    run_phase(30, 0);
    repeat (4) begin
      program_random();
      run_phase(60, 0);
    end

    if (mismatches == 0 && words_due == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/dtpt_pkg.sv
hw/rtl/dtpt_cfg_regs.sv
hw/rtl/dtpt_ctrl.sv
hw/rtl/dtpt_out_skid.sv
hw/rtl/door_triggered_pump_timer.sv
sim/door_timer_checker.sv
sim/tb_top.sv
